// ===== design/adf_pkg.sv =====
// ============================================================================
// adf_pkg
// Shared types and constants for the advertising data element finder.
// ============================================================================
`default_nettype none

package adf_pkg;

    localparam int BYTE_W = 8;

    typedef enum logic [4:0] {
        PH_LEN   = 5'b00001,
        PH_TYPE  = 5'b00010,
        PH_MATCH = 5'b00100,
        PH_SKIP  = 5'b01000,
        PH_DRAIN = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_MALFORMED = 2'd2
    } status_t;

    typedef struct packed {
        phase_t              phase;
        logic [BYTE_W-1:0]   bytes_left;
        logic [BYTE_W-1:0]   payload_count;
    } parse_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   payload_byte;
        logic                byte_valid;
        logic                done_res;
        status_t             status;
        logic [BYTE_W-1:0]   payload_length;
    } result_t;

endpackage

`default_nettype wire

// ===== design/adf_step.sv =====
// ============================================================================
// adf_step
// Next-state and result logic for one record byte of the element parser.
// ============================================================================
`default_nettype none

module adf_step
    import adf_pkg::*;
(
    input  parse_state_t        cur,
    input  logic [BYTE_W-1:0]   data_byte,
    input  logic                is_last,
    input  logic [BYTE_W-1:0]   target_type,
    output parse_state_t        nxt,
    output logic                has_res,
    output result_t             res
);

    logic [BYTE_W-1:0] bl_dec;
    logic [BYTE_W-1:0] pc_inc;
    logic              fin;
    status_t           fin_st;

    assign bl_dec = cur.bytes_left - BYTE_W'(1);
    assign pc_inc = cur.payload_count + BYTE_W'(1);

    always_comb
    begin
        nxt     = cur;
        has_res = 1'b0;
        res     = '0;
        fin     = 1'b0;
        fin_st  = ST_FOUND;
        unique case (cur.phase)
            PH_LEN:
            begin
                if ((data_byte == '0) || is_last)
                begin
                    fin    = 1'b1;
                    fin_st = ST_MALFORMED;
                end
                else
                begin
                    nxt.bytes_left = data_byte;
                    nxt.phase      = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                nxt.bytes_left    = bl_dec;
                nxt.payload_count = '0;
                if (data_byte == target_type)
                begin
                    if (bl_dec == '0)
                    begin
                        fin    = 1'b1;
                        fin_st = ST_FOUND;
                    end
                    else if (is_last)
                    begin
                        fin    = 1'b1;
                        fin_st = ST_MALFORMED;
                    end
                    else
                    begin
                        nxt.phase = PH_MATCH;
                    end
                end
                else if (bl_dec == '0)
                begin
                    if (is_last)
                    begin
                        fin    = 1'b1;
                        fin_st = ST_NOT_FOUND;
                    end
                    else
                    begin
                        nxt.phase = PH_LEN;
                    end
                end
                else if (is_last)
                begin
                    fin    = 1'b1;
                    fin_st = ST_MALFORMED;
                end
                else
                begin
                    nxt.phase = PH_SKIP;
                end
            end
            PH_MATCH:
            begin
                has_res           = 1'b1;
                res.payload_byte  = data_byte;
                res.byte_valid    = 1'b1;
                nxt.payload_count = pc_inc;
                nxt.bytes_left    = bl_dec;
                if (bl_dec == '0)
                begin
                    fin                = 1'b1;
                    fin_st             = ST_FOUND;
                    res.payload_length = pc_inc;
                end
                else if (is_last)
                begin
                    fin    = 1'b1;
                    fin_st = ST_MALFORMED;
                end
            end
            PH_SKIP:
            begin
                nxt.bytes_left = bl_dec;
                if (bl_dec == '0)
                begin
                    if (is_last)
                    begin
                        fin    = 1'b1;
                        fin_st = ST_NOT_FOUND;
                    end
                    else
                    begin
                        nxt.phase = PH_LEN;
                    end
                end
                else if (is_last)
                begin
                    fin    = 1'b1;
                    fin_st = ST_MALFORMED;
                end
            end
            PH_DRAIN:
            begin
                if (is_last)
                begin
                    nxt.phase = PH_LEN;
                end
            end
            default:
            begin
                nxt.phase = PH_LEN;
            end
        endcase

        if (fin)
        begin
            has_res      = 1'b1;
            res.done_res = 1'b1;
            res.status   = fin_st;
            nxt.phase    = is_last ? PH_LEN : PH_DRAIN;
        end
    end

endmodule

`default_nettype wire

// ===== design/adv_data_tlv_field_finder.sv =====
// ============================================================================
// adv_data_tlv_field_finder
// Finds the first element of a given type in an advertising record.
// ============================================================================
// The block takes one record byte per cycle and keeps that rate for as long
// as results are taken: each accepted word lands in an input register, the
// parser updates its phase and counters from it when the word is consumed,
// and any result is loaded into the output register at that point. The input
// side stalls only while the output register holds a result that has not
// been taken and the waiting byte would produce another. The user must write
// the target type register only while the block is idle; the block itself
// does not enforce this. The target type register resets to 1.
`default_nettype none

module adv_data_tlv_field_finder
    import adf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [BYTE_W-1:0] data_byte,
    input  wire logic              is_last,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [BYTE_W-1:0]      payload_byte,
    output logic                   byte_valid,
    output logic                   done_res,
    output logic [1:0]             status,
    output logic [BYTE_W-1:0]      payload_length,
    input  wire logic              cfg_wr_en,
    input  wire logic [BYTE_W-1:0] cfg_wr_data
);

    logic [BYTE_W-1:0] target_reg;
    logic              in_vld_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;
    parse_state_t      state_reg;
    parse_state_t      state_next;
    logic              out_vld_reg;
    result_t           out_res_reg;
    logic              step_has_res;
    result_t           step_res;
    logic              adv;
    logic              in_accept;

    adf_step u_step (
        .cur         (state_reg),
        .data_byte   (in_byte_reg),
        .is_last     (in_last_reg),
        .target_type (target_reg),
        .nxt         (state_next),
        .has_res     (step_has_res),
        .res         (step_res)
    );

    assign adv       = in_vld_reg && (!step_has_res || !out_vld_reg || out_ready);
    assign in_ready  = !in_vld_reg || adv;
    assign in_accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg  <= BYTE_W'(1);
            in_vld_reg  <= 1'b0;
            state_reg   <= '{phase: PH_LEN, bytes_left: '0, payload_count: '0};
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                target_reg <= cfg_wr_data;
            end
            if (in_accept)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (adv)
            begin
                in_vld_reg <= 1'b0;
            end
            if (adv)
            begin
                state_reg <= state_next;
            end
            if (adv && step_has_res)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= is_last;
        end
        if (adv && step_has_res)
        begin
            out_res_reg <= step_res;
        end
    end

    assign out_valid      = out_vld_reg;
    assign payload_byte   = out_res_reg.payload_byte;
    assign byte_valid     = out_res_reg.byte_valid;
    assign done_res       = out_res_reg.done_res;
    assign status         = out_res_reg.status;
    assign payload_length = out_res_reg.payload_length;

    // Every result carries a data byte, an outcome, or both.
    a_res_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_valid || done_res))
        else $error("result carries neither data nor outcome");

    // A nonzero length is only reported with a found outcome on a data byte.
    a_len_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (payload_length != '0)) |->
            (done_res && byte_valid && (status == ST_FOUND)))
        else $error("payload length outside a found result");

    // A held input word is not overwritten before the parser consumes it.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !adv) |=> (in_vld_reg && $stable(in_byte_reg)
            && $stable(in_last_reg)))
        else $error("held input word lost");

    // The parser state only moves when a word is consumed.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(state_reg))
        else $error("parser state moved without a word");

endmodule

`default_nettype wire
